FILE: rtl/capwm_pkg.sv
// Shared types and constants for the center-aligned three-phase PWM.
`default_nettype none
package capwm_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned PRE_W   = 4;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX = 2;

  localparam logic [CNT_W-1:0] PERIOD_RST  = 16'd5000;
  localparam logic [PRE_W-1:0] SOC_A_RST   = 4'd1;
  localparam logic [PRE_W-1:0] SOC_B_RST   = 4'd10;
  localparam logic [CNT_W-1:0] CMP_RST     = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_ENABLE = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX-1:0] {
    REG_PERIOD      = 2'd0,
    REG_SOC_A_EVERY = 2'd1,
    REG_SOC_B_EVERY = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] cmp_u;
    logic [CNT_W-1:0] cmp_v;
    logic [CNT_W-1:0] cmp_w;
    logic             enable;
  } in_t;

  typedef struct packed {
    logic             phase_u;
    logic             phase_v;
    logic             phase_w;
    logic             driver_on;
    logic             soc_a;
    logic             soc_b;
    logic [CNT_W-1:0] count;
    logic             falling;
  } out_t;

endpackage
`default_nettype wire

FILE: rtl/capwm_presc.sv
// Peak prescaler that raises a conversion trigger every Nth carrier peak.
`default_nettype none
module capwm_presc (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [capwm_pkg::PRE_W-1:0] every,
  input  wire logic                        peak,
  output logic                             pulse
);

  logic [capwm_pkg::PRE_W-1:0] cnt_r;
  logic [capwm_pkg::PRE_W-1:0] cnt_nxt;
  logic [capwm_pkg::PRE_W-1:0] cnt_inc;

  always_comb begin
    cnt_inc = cnt_r + capwm_pkg::PRE_W'(1);
    cnt_nxt = cnt_r;
    pulse   = 1'b0;
    if (peak) begin
      // A divider of zero parks the counter and never fires.
      if (every == '0) begin
        cnt_nxt = '0;
      end else if (cnt_inc >= every) begin
        cnt_nxt = '0;
        pulse   = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/center_aligned_three_phase_pwm.sv
// Top level of the center-aligned three-phase PWM with up-down carrier.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_stall    capwm_pkg::in_t
//  out_     output     out_valid / out_stall  capwm_pkg::out_t
//  cfg_     input      cfg_wr_en              cfg_index, cfg_wdata
//
// The carrier step, compare match and prescalers sit between the accepted beat
// and the result register, so a beat may enter every cycle while in_stall is
// low, and its result appears in the output register on the next one.
// Reset is synchronous; it restores the register defaults and parks all phases low.
// in_stall follows out_stall only while a result is held in the output register.
`default_nettype none
module center_aligned_three_phase_pwm (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire capwm_pkg::in_t                in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output capwm_pkg::out_t                    out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [capwm_pkg::CFG_IDX-1:0] cfg_index,
  input  wire logic [capwm_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int unsigned CW = capwm_pkg::CNT_W;

  logic [CW-1:0]               period_r;
  logic [capwm_pkg::PRE_W-1:0] soc_a_every_r;
  logic [capwm_pkg::PRE_W-1:0] soc_b_every_r;

  logic [CW-1:0] carrier_r, carrier_nxt;
  logic          down_r, down_nxt;
  logic [CW-1:0] cmp_r [3];
  logic [CW-1:0] cmp_nxt [3];
  logic [2:0]    phase_r, phase_nxt;
  logic          drv_r, drv_nxt;

  logic            accept;
  logic            tick;
  logic            peak;
  logic            soc_a;
  logic            soc_b;
  logic            out_valid_r;
  capwm_pkg::out_t out_r;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign tick      = accept && (capwm_pkg::kind_t'(in_data.kind) == capwm_pkg::KIND_TICK);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    carrier_nxt = carrier_r;
    down_nxt    = down_r;
    phase_nxt   = phase_r;
    drv_nxt     = drv_r;
    peak        = 1'b0;
    for (int p = 0; p < 3; p++) begin
      cmp_nxt[p] = cmp_r[p];
    end
    if (accept) begin
      case (capwm_pkg::kind_t'(in_data.kind))
        capwm_pkg::KIND_TICK: begin
          if (!down_r) begin
            // A counter left above a lowered period snaps to it as a peak.
            carrier_nxt = (carrier_r < period_r) ? carrier_r + CW'(1) : period_r;
            if (carrier_nxt >= period_r) begin
              down_nxt = 1'b1;
              peak     = 1'b1;
            end
          end else begin
            if (carrier_r != '0) begin
              carrier_nxt = carrier_r - CW'(1);
            end
            if (carrier_nxt == '0) begin
              down_nxt = 1'b0;
            end
          end
          for (int p = 0; p < 3; p++) begin
            if (carrier_nxt == cmp_r[p]) begin
              phase_nxt[p] = !down_nxt;
            end
          end
        end
        capwm_pkg::KIND_LOAD: begin
          cmp_nxt[0] = in_data.cmp_u;
          cmp_nxt[1] = in_data.cmp_v;
          cmp_nxt[2] = in_data.cmp_w;
        end
        capwm_pkg::KIND_ENABLE: begin
          drv_nxt = in_data.enable;
        end
        default: begin
        end
      endcase
    end
  end

  capwm_presc u_presc_a (
    .clk   (clk),
    .rst_n (rst_n),
    .every (soc_a_every_r),
    .peak  (peak && tick),
    .pulse (soc_a)
  );

  capwm_presc u_presc_b (
    .clk   (clk),
    .rst_n (rst_n),
    .every (soc_b_every_r),
    .peak  (peak && tick),
    .pulse (soc_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r      <= capwm_pkg::PERIOD_RST;
      soc_a_every_r <= capwm_pkg::SOC_A_RST;
      soc_b_every_r <= capwm_pkg::SOC_B_RST;
    end else if (cfg_wr_en) begin
      case (capwm_pkg::reg_idx_t'(cfg_index))
        capwm_pkg::REG_PERIOD:      period_r      <= cfg_wdata;
        capwm_pkg::REG_SOC_A_EVERY: soc_a_every_r <= cfg_wdata[capwm_pkg::PRE_W-1:0];
        capwm_pkg::REG_SOC_B_EVERY: soc_b_every_r <= cfg_wdata[capwm_pkg::PRE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r   <= '0;
      down_r      <= 1'b0;
      phase_r     <= '0;
      drv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < 3; p++) begin
        cmp_r[p] <= capwm_pkg::CMP_RST;
      end
    end else begin
      carrier_r <= carrier_nxt;
      down_r    <= down_nxt;
      phase_r   <= phase_nxt;
      drv_r     <= drv_nxt;
      for (int p = 0; p < 3; p++) begin
        cmp_r[p] <= cmp_nxt[p];
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload is loaded only with an accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.phase_u   <= phase_nxt[0];
      out_r.phase_v   <= phase_nxt[1];
      out_r.phase_w   <= phase_nxt[2];
      out_r.driver_on <= drv_nxt;
      out_r.soc_a     <= soc_a && tick;
      out_r.soc_b     <= soc_b && tick;
      out_r.count     <= carrier_nxt;
      out_r.falling   <= down_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/capwm_chk.sv
// Port-level checker for the PWM top level, attached by bind.
`default_nettype none
module capwm_chk (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire capwm_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  a_soc_at_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.soc_a || out_data.soc_b) |-> out_data.falling)
    else $error("conversion trigger outside a carrier peak");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output register was free");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind center_aligned_three_phase_pwm capwm_chk u_capwm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the center-aligned three-phase PWM with its own cycle predictor.
`timescale 1ns / 1ps
module tb_top;
  import capwm_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_PHASES = 3;
  localparam int LONG_HOLD = 300;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_wr_en;
  logic [CFG_IDX-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  center_aligned_three_phase_pwm dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predicted PWM state and register copies.
  logic [CNT_W-1:0] period_reg;
  logic [PRE_W-1:0] soc_a_reg;
  logic [PRE_W-1:0] soc_b_reg;
  logic [CNT_W-1:0] carrier_cnt;
  logic count_down;
  logic [CNT_W-1:0] cmp_val [NUM_PHASES];
  logic [NUM_PHASES-1:0] phase_lvl;
  logic drv_lvl;
  logic [PRE_W-1:0] peaks_a;
  logic [PRE_W-1:0] peaks_b;

  out_t pending_outputs[$];
  int errors;

  bit sender_gaps;
  int burst_left;
  stall_mode_t stall_mode;
  int hold_request;
  int hold_left;
  int stall_phase;

  function automatic logic prescale_fire(inout logic [PRE_W-1:0] cnt,
                                         input logic [PRE_W-1:0] every);
    if (every == '0) begin
      cnt = '0;
      return 1'b0;
    end
    cnt = cnt + 1'b1;
    if (cnt >= every) begin
      cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic step_pwm(input in_t beat, output out_t res);
    logic peak;
    logic sa;
    logic sb;
    peak = 1'b0;
    sa = 1'b0;
    sb = 1'b0;
    case (beat.kind)
      KIND_TICK: begin
        // The counter moves first, then the direction, then the compare match.
        if (!count_down) begin
          if (carrier_cnt < period_reg) carrier_cnt = carrier_cnt + 1'b1;
          else carrier_cnt = period_reg;
          if (carrier_cnt >= period_reg) begin
            count_down = 1'b1;
            peak = 1'b1;
          end
        end else begin
          if (carrier_cnt > 0) carrier_cnt = carrier_cnt - 1'b1;
          if (carrier_cnt == 0) count_down = 1'b0;
        end
        for (int p = 0; p < NUM_PHASES; p++) begin
          if (carrier_cnt == cmp_val[p]) phase_lvl[p] = !count_down;
        end
        if (peak) begin
          sa = prescale_fire(peaks_a, soc_a_reg);
          sb = prescale_fire(peaks_b, soc_b_reg);
        end
      end
      KIND_LOAD: begin
        cmp_val[0] = beat.cmp_u;
        cmp_val[1] = beat.cmp_v;
        cmp_val[2] = beat.cmp_w;
      end
      KIND_ENABLE: begin
        drv_lvl = beat.enable;
      end
      default: begin
      end
    endcase
    res.phase_u = phase_lvl[0];
    res.phase_v = phase_lvl[1];
    res.phase_w = phase_lvl[2];
    res.driver_on = drv_lvl;
    res.soc_a = sa;
    res.soc_b = sb;
    res.count = carrier_cnt;
    res.falling = count_down;
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
                             input logic [CNT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, out_data);
        errors++;
      end else begin
        exp_beat = pending_outputs.pop_front();
        check_field("phase_u", CNT_W'(exp_beat.phase_u), CNT_W'(out_data.phase_u));
        check_field("phase_v", CNT_W'(exp_beat.phase_v), CNT_W'(out_data.phase_v));
        check_field("phase_w", CNT_W'(exp_beat.phase_w), CNT_W'(out_data.phase_w));
        check_field("driver_on", CNT_W'(exp_beat.driver_on), CNT_W'(out_data.driver_on));
        check_field("soc_a", CNT_W'(exp_beat.soc_a), CNT_W'(out_data.soc_a));
        check_field("soc_b", CNT_W'(exp_beat.soc_b), CNT_W'(out_data.soc_b));
        check_field("count", exp_beat.count, out_data.count);
        check_field("falling", CNT_W'(exp_beat.falling), CNT_W'(out_data.falling));
      end
    end
  end

  // Receiver back-pressure; a long hold-off is counted down here.
  always @(negedge clk) begin
    logic stall_now;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      stall_now = 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        STALL_RANDOM: stall_now = ($urandom_range(0, 99) < 35);
        STALL_PATTERN: begin
          stall_now = (stall_phase < 2);
          stall_phase = (stall_phase + 1) % 5;
        end
        default: stall_now = 1'b0;
      endcase
    end
    out_stall <= stall_now;
  end

  task automatic send_beat(input in_t beat);
    out_t exp_beat;
    in_data <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_pwm(beat, exp_beat);
    pending_outputs.push_back(exp_beat);
    @(negedge clk);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes all three registers; only called with the block idle.
  task automatic set_config(input logic [CNT_W-1:0] per, input logic [PRE_W-1:0] a_every,
                            input logic [PRE_W-1:0] b_every);
    reg_idx_t idx;
    logic [CFG_W-1:0] value;
    drain();
    for (int i = 0; i < 3; i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_PERIOD: value = per;
        REG_SOC_A_EVERY: value = {12'($urandom), a_every};
        default: value = {12'($urandom), b_every};
      endcase
      cfg_index <= idx;
      cfg_wdata <= value;
      cfg_wr_en <= 1'b1;
      @(posedge clk);
      case (idx)
        REG_PERIOD: period_reg = value;
        REG_SOC_A_EVERY: soc_a_reg = value[PRE_W-1:0];
        default: soc_b_reg = value[PRE_W-1:0];
      endcase
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic in_t make_beat(input logic [1:0] kind, input logic [CNT_W-1:0] u,
                                    input logic [CNT_W-1:0] v, input logic [CNT_W-1:0] w,
                                    input logic en);
    in_t b;
    b.kind = kind;
    b.cmp_u = u;
    b.cmp_v = v;
    b.cmp_w = w;
    b.enable = en;
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] pick_compare();
    case ($urandom_range(0, 7))
      0: return CNT_W'($urandom);
      1: return period_reg + 1'b1;
      2: return CNT_W'($urandom_range(0, 40));
      3: return period_reg;
      default: return CNT_W'($urandom_range(0, period_reg));
    endcase
  endfunction

  // Mostly ticks, plus enable and unused beats and loads whose compares fall inside, at or past the carrier range.
  function automatic in_t random_beat();
    in_t b;
    int r;
    b = make_beat(KIND_TICK, CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
                  1'($urandom));
    r = $urandom_range(0, 99);
    if (r < 72) begin
      b.kind = KIND_TICK;
    end else if (r < 84) begin
      b.kind = KIND_LOAD;
      b.cmp_u = pick_compare();
      b.cmp_v = pick_compare();
      b.cmp_w = pick_compare();
    end else if (r < 94) begin
      b.kind = KIND_ENABLE;
    end else begin
      b.kind = KIND_UNUSED;
    end
    return b;
  endfunction

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      send_beat(make_beat(KIND_TICK, CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
                          1'($urandom)));
    end
  endtask

  task automatic test_operations();
    send_beat(make_beat(KIND_UNUSED, '1, '1, '1, 1'b1));
    send_ticks(1);
    send_beat(make_beat(KIND_LOAD, 16'd2, 16'd0, 16'hFFFF, 1'b1));
    send_ticks(2);
    send_beat(make_beat(KIND_ENABLE, '1, '1, '1, 1'b1));
    send_beat(make_beat(KIND_ENABLE, '0, '0, '0, 1'b0));
    send_beat(make_beat(KIND_ENABLE, '0, '0, '0, 1'b1));
  endtask

  // With a zero period the carrier stays at zero and peaks on every other tick.
  task automatic test_period_zero();
    set_config(16'd0, 4'd0, 4'd15);
    send_beat(make_beat(KIND_LOAD, 16'd0, 16'd0, 16'd1, 1'b0));
    send_ticks(6);
  endtask

  // Lowering the period under the carrier forces a peak on the next tick.
  task automatic test_period_shrink();
    set_config(16'd6, 4'd1, 4'd2);
    send_beat(make_beat(KIND_LOAD, 16'd2, 16'd6, 16'd3, 1'b0));
    send_ticks(4);
    set_config(16'd2, 4'd1, 4'd2);
    send_ticks(4);
  endtask

  task automatic test_backpressure();
    set_config(16'd5, 4'd3, 4'd4);
    sender_gaps = 1'b0;
    stall_mode = STALL_NONE;
    hold_request = LONG_HOLD;
    for (int i = 0; i < 60; i++) send_beat(random_beat());
    drain();
  endtask

  task automatic test_random_settings();
    logic [CNT_W-1:0] per;
    logic [PRE_W-1:0] a_every;
    logic [PRE_W-1:0] b_every;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: per = 16'd1;
        1: per = 16'd0;
        2: per = 16'hFFFE;
        3: per = 16'hFFFF;
        default: per = CNT_W'($urandom_range(2, 24));
      endcase
      a_every = (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 : PRE_W'($urandom_range(0, 15));
      b_every = (ph == 0) ? 4'd15 : (ph == 1) ? 4'd0 : PRE_W'($urandom_range(0, 15));
      set_config(per, a_every, b_every);
      sender_gaps = (ph % 3 != 0);
      stall_mode = stall_mode_t'((ph + ph / 3) % 3);
      for (int i = 0; i < 70; i++) send_beat(random_beat());
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    out_stall = 1'b0;
    errors = 0;
    sender_gaps = 1'b0;
    burst_left = 0;
    stall_mode = STALL_NONE;
    hold_request = 0;
    hold_left = 0;
    stall_phase = 0;
    period_reg = PERIOD_RST;
    soc_a_reg = SOC_A_RST;
    soc_b_reg = SOC_B_RST;
    carrier_cnt = '0;
    count_down = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) cmp_val[p] = CMP_RST;
    phase_lvl = '0;
    drv_lvl = 1'b0;
    peaks_a = '0;
    peaks_b = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_operations();
    test_period_zero();
    test_period_shrink();
    test_backpressure();
    test_random_settings();

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/capwm_pkg.sv
rtl/capwm_presc.sv
rtl/center_aligned_three_phase_pwm.sv
rtl/capwm_chk.sv
dv/tb_top.sv
